// File: src/aks_pkg.sv
`default_nettype none
package aks_pkg;

  localparam int NBIND      = 4;
  localparam int LEVEL_W    = 16;
  localparam int TICK_W     = 32;
  localparam int CODE_W     = 16;
  localparam int CTL_W      = 32;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int IDX_W      = 2;
  localparam int TAP_TICKS  = 5;
  localparam int LEVEL_BITS = 16;

  localparam logic [TICK_W-1:0]  ENDLESS    = 32'hFFFF_FFFF;
  localparam logic [LEVEL_W-1:0] LEVEL_MASK = (LEVEL_BITS >= LEVEL_W) ? {LEVEL_W{1'b1}} :
                                              LEVEL_W'((64'd1 << LEVEL_BITS) - 64'd1);

  typedef enum logic [1:0] {
    KIND_DOWN   = 2'd0,
    KIND_UP     = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FLOOR     = 3'd0,
    CFG_PRESS_BEG = 3'd1,
    CFG_PRESS_FUL = 3'd2,
    CFG_REL_BEG   = 3'd3,
    CFG_REL_FUL   = 3'd4,
    CFG_CONTROLS  = 3'd5,
    CFG_CODES     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] analog_level;
    logic [TICK_W-1:0]  tick_now;
  } in_item_t;

  typedef struct packed {
    kind_t              kind;
    logic [IDX_W-1:0]   binding_index;
    logic [CODE_W-1:0]  keycode;
    logic               any_active;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] analog_floor;
    logic [LEVEL_W-1:0] press_begin_level;
    logic [LEVEL_W-1:0] press_full_level;
    logic [LEVEL_W-1:0] release_begin_level;
    logic [LEVEL_W-1:0] release_full_level;
    logic [CTL_W-1:0]   phase_controls;
  } thr_cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]             prev_level;
    logic [NBIND-1:0]               active;
    logic [NBIND-1:0][TICK_W-1:0]   expiry_tick;
  } key_state_t;

  typedef struct packed {
    logic [NBIND-1:0] changed;
    logic [NBIND-1:0] active;
    logic             any;
  } step_rec_t;

endpackage
`default_nettype wire

// File: src/aks_in_if.sv
`default_nettype none
interface aks_in_if import aks_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/aks_out_if.sv
`default_nettype none
interface aks_out_if import aks_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/aks_step.sv
`default_nettype none
module aks_step import aks_pkg::*; (
  input  key_state_t st,
  input  thr_cfg_t   cfg,
  input  in_item_t   item,
  output key_state_t st_nxt,
  output step_rec_t  rec
);

  always_comb begin
    logic [LEVEL_W-1:0]           cur;
    logic [LEVEL_W-1:0]           prev;
    logic [LEVEL_W-1:0]           ct;
    logic [LEVEL_W-1:0]           pt;
    logic                         rise;
    logic                         fall;
    logic [NBIND-1:0]             fire;
    logic [NBIND-1:0]             act;
    logic [NBIND-1:0][TICK_W-1:0] et;
    logic [TICK_W-1:0]            tap_end;
    logic [7:0]                   ctl;

    cur  = item.analog_level & LEVEL_MASK;
    prev = st.prev_level & LEVEL_MASK;
    ct   = (cur > cfg.analog_floor) ? cur - cfg.analog_floor : '0;
    pt   = (prev > cfg.analog_floor) ? prev - cfg.analog_floor : '0;
    rise = cur > prev;
    fall = cur < prev;

    fire[0] = rise && (ct >= cfg.press_begin_level) && (pt < cfg.press_begin_level);
    fire[1] = rise && (ct >= cfg.press_full_level) && (pt < cfg.press_full_level);
    fire[2] = fall && (ct <= cfg.release_begin_level) && (pt > cfg.release_begin_level);
    fire[3] = fall && (ct <= cfg.release_full_level) && (pt > cfg.release_full_level);

    tap_end = item.tick_now + TICK_W'(TAP_TICKS);
    act     = st.active;
    et      = st.expiry_tick;
    ctl     = '0;

    // phases in firing order, the later one overrides
    for (int p = 0; p < NBIND; p++) begin
      if (fire[p]) begin
        for (int i = 0; i < NBIND; i++) begin
          ctl = cfg.phase_controls[8*i +: 8];
          if (ctl[2*p]) begin
            et[i]  = ctl[2*p+1] ? ENDLESS : tap_end;
            act[i] = 1'b1;
          end else begin
            act[i] = 1'b0;
          end
        end
      end
    end

    // expiry on the plain unsigned compare
    for (int i = 0; i < NBIND; i++) begin
      if (item.tick_now > et[i]) begin
        act[i] = 1'b0;
      end
    end

    st_nxt.prev_level  = cur;
    st_nxt.active      = act;
    st_nxt.expiry_tick = et;
    rec.changed        = act ^ st.active;
    rec.active         = act;
    rec.any            = |act;
  end

endmodule
`default_nettype wire

// File: src/analog_key_stroke_trigger.sv
// analog key stroke trigger, four bindings
// in_ch carries one transaction per key scan: a travel sample and the current tick.
// out_ch returns, per scan, one down or up transaction for each binding whose
// state changed (binding order 0 to 3), then one status transaction with last set.
// cfg_we / cfg_index / cfg_data write the thresholds, floor, phase controls and
// keycodes; write them only while the block is idle.
// a scan that is taken passes the holding register and then the serialiser registers
// before its first result transaction appears.
// throughput: a scan occupies the output serialiser for its status transaction and
// one transaction per binding that changed; the serialiser, one transaction a cycle
// while ready, sets the rate. the step logic is one pass, so a new scan is taken
// every cycle when each yields only its status transaction and out_ch.ready stays high.
// a one-entry holding register sits between the step logic and the serialiser, so
// the next scan is taken while results of the previous one still drain.
// when the receiver stalls, the current result holds steady, the holding register
// fills and in_ch.ready then drops until the serialiser moves on.
// reset zeroes the configuration, bindings and end times and empties both stages.
`default_nettype none
module analog_key_stroke_trigger import aks_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  aks_in_if.sink                    in_ch,
  aks_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  // configuration registers
  thr_cfg_t                       cfg_r;
  logic [NBIND-1:0][CODE_W-1:0]   codes_r;

  // key state
  key_state_t st_r;
  key_state_t st_nxt;
  step_rec_t  rec;

  // holding stage
  logic      hold_v_r;
  step_rec_t hold_rec_r;

  // output serialiser
  logic             cur_v_r;
  logic [NBIND-1:0] cur_pend_r;
  logic [NBIND-1:0] cur_act_r;
  logic             cur_any_r;

  logic             in_fire;
  logic             in_rdy;
  logic             out_fire;
  logic             is_status;
  logic             cur_done;
  logic             cur_load;
  logic [IDX_W-1:0] emit_idx;

  aks_step u_step (
    .st     (st_r),
    .cfg    (cfg_r),
    .item   (in_ch.data),
    .st_nxt (st_nxt),
    .rec    (rec)
  );

  // lowest pending binding goes first
  always_comb begin
    emit_idx = '0;
    for (int i = NBIND - 1; i >= 0; i--) begin
      if (cur_pend_r[i]) begin
        emit_idx = IDX_W'(i);
      end
    end
  end

  assign is_status = (cur_pend_r == '0);
  assign out_fire  = cur_v_r && out_ch.ready;
  assign cur_done  = out_fire && is_status;
  assign cur_load  = hold_v_r && (!cur_v_r || cur_done);
  assign in_rdy    = !hold_v_r || cur_load;
  assign in_fire   = in_ch.valid && in_rdy;

  assign in_ch.ready = in_rdy;

  // result transaction
  always_comb begin
    out_ch.valid = cur_v_r;
    if (is_status) begin
      out_ch.data.kind          = KIND_STATUS;
      out_ch.data.binding_index = '0;
      out_ch.data.keycode       = '0;
      out_ch.data.last          = 1'b1;
    end else begin
      out_ch.data.kind          = cur_act_r[emit_idx] ? KIND_DOWN : KIND_UP;
      out_ch.data.binding_index = emit_idx;
      out_ch.data.keycode       = codes_r[emit_idx];
      out_ch.data.last          = 1'b0;
    end
    out_ch.data.any_active = cur_any_r;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '0;
      codes_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FLOOR:     cfg_r.analog_floor        <= cfg_data[LEVEL_W-1:0];
        CFG_PRESS_BEG: cfg_r.press_begin_level   <= cfg_data[LEVEL_W-1:0];
        CFG_PRESS_FUL: cfg_r.press_full_level    <= cfg_data[LEVEL_W-1:0];
        CFG_REL_BEG:   cfg_r.release_begin_level <= cfg_data[LEVEL_W-1:0];
        CFG_REL_FUL:   cfg_r.release_full_level  <= cfg_data[LEVEL_W-1:0];
        CFG_CONTROLS:  cfg_r.phase_controls      <= cfg_data[CTL_W-1:0];
        CFG_CODES:     codes_r                   <= cfg_data;
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // key state advances on every accepted scan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // holding stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= in_fire || (hold_v_r && !cur_load);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      hold_rec_r <= rec;
    end
  end

  // serialiser control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r    <= 1'b0;
      cur_pend_r <= '0;
    end else if (cur_load) begin
      cur_v_r    <= 1'b1;
      cur_pend_r <= hold_rec_r.changed;
    end else if (cur_done) begin
      cur_v_r    <= 1'b0;
    end else if (out_fire) begin
      cur_pend_r[emit_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_load) begin
      cur_act_r <= hold_rec_r.active;
      cur_any_r <= hold_rec_r.any;
    end
  end

endmodule
`default_nettype wire

// File: src/aks_chk.sv
`default_nettype none
module aks_chk import aks_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // stalled result transaction holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // last marks the status transaction and nothing else
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last == (out_data.kind == KIND_STATUS)))
    else $error("last flag does not match status kind");

  // status carries no binding
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_STATUS |->
      out_data.binding_index == '0 && out_data.keycode == '0)
    else $error("status with binding fields set");

  // a down event means some binding is active
  a_down_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind == KIND_DOWN |-> out_data.any_active)
    else $error("down event with nothing active");

  // events of one scan come in rising binding order, then the status
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last |=>
      out_valid && (out_data.last || out_data.binding_index > $past(out_data.binding_index)))
    else $error("events out of order");

endmodule

bind analog_key_stroke_trigger aks_chk u_aks_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);
`default_nettype wire

// File: tb/sv/analog_key_stroke_trigger_test.sv
`timescale 1ns / 1ps
module analog_key_stroke_trigger_test import aks_pkg::*; ();

  // phase numbers inside a binding's control byte
  localparam int PH_PRESS_BEGIN   = 0;
  localparam int PH_PRESS_FULL    = 1;
  localparam int PH_RELEASE_BEGIN = 2;
  localparam int PH_RELEASE_FULL  = 3;

  // register index with no register behind it, writes must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  aks_in_if  in_ch ();
  aks_out_if out_ch ();

  analog_key_stroke_trigger u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // predictor: own copy of the settings and the key state
  // ---------------------------------------------------------------------
  logic [LEVEL_W-1:0] set_floor;
  logic [LEVEL_W-1:0] set_press_begin;
  logic [LEVEL_W-1:0] set_press_full;
  logic [LEVEL_W-1:0] set_release_begin;
  logic [LEVEL_W-1:0] set_release_full;
  logic [CTL_W-1:0]   set_controls;
  logic [CFG_W-1:0]   set_codes;

  logic [LEVEL_W-1:0] last_level;
  logic [NBIND-1:0]   bound_active;
  logic [TICK_W-1:0]  bind_end [NBIND];

  // key events still owed by the block, oldest first
  out_item_t expected_events [$];
  // key scans waiting to be offered on the input channel
  in_item_t  pending_scans [$];

  int unsigned mismatches      = 0;
  int unsigned scans_taken     = 0;
  int unsigned scans_driven    = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used   = 0;
  logic [TICK_W-1:0] tick_base = '0;

  function automatic void clear_key_state();
    set_floor         = '0;
    set_press_begin   = '0;
    set_press_full    = '0;
    set_release_begin = '0;
    set_release_full  = '0;
    set_controls      = '0;
    set_codes         = '0;
    last_level        = '0;
    bound_active      = '0;
    for (int b = 0; b < NBIND; b++) bind_end[b] = '0;
  endfunction

  // travel above the floor, never below zero
  function automatic logic [LEVEL_W-1:0] net_travel(logic [LEVEL_W-1:0] lvl);
    return (lvl > set_floor) ? lvl - set_floor : '0;
  endfunction

  // a fired phase sets every binding that enables it and clears the rest
  function automatic void trigger_phase(int ph, logic [TICK_W-1:0] tick);
    logic [7:0] ctl;
    for (int b = 0; b < NBIND; b++) begin
      ctl = set_controls[8*b +: 8];
      if (ctl[2*ph]) begin
        bind_end[b]     = ctl[2*ph+1] ? ENDLESS : tick + TICK_W'(TAP_TICKS);
        bound_active[b] = 1'b1;
      end else begin
        // end time is left as it was
        bound_active[b] = 1'b0;
      end
    end
  endfunction

  function automatic void predict_key_scan(in_item_t scan);
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W-1:0] prv;
    logic [LEVEL_W-1:0] ct;
    logic [LEVEL_W-1:0] pt;
    logic [NBIND-1:0]   was;
    logic               any;
    out_item_t          ev;
    cur = scan.analog_level & LEVEL_MASK;
    prv = last_level & LEVEL_MASK;
    ct  = net_travel(cur);
    pt  = net_travel(prv);
    was = bound_active;
    // direction comes from the raw samples, thresholds from net travel
    if (cur > prv) begin
      if (ct >= set_press_begin && pt < set_press_begin)
        trigger_phase(PH_PRESS_BEGIN, scan.tick_now);
      if (ct >= set_press_full && pt < set_press_full)
        trigger_phase(PH_PRESS_FULL, scan.tick_now);
    end
    if (cur < prv) begin
      if (ct <= set_release_begin && pt > set_release_begin)
        trigger_phase(PH_RELEASE_BEGIN, scan.tick_now);
      if (ct <= set_release_full && pt > set_release_full)
        trigger_phase(PH_RELEASE_FULL, scan.tick_now);
    end
    // plain unsigned expiry, a wrapped end time expires at once
    for (int b = 0; b < NBIND; b++)
      if (scan.tick_now > bind_end[b]) bound_active[b] = 1'b0;
    any = |bound_active;
    for (int b = 0; b < NBIND; b++) begin
      if (bound_active[b] != was[b]) begin
        ev.kind          = bound_active[b] ? KIND_DOWN : KIND_UP;
        ev.binding_index = IDX_W'(b);
        ev.keycode       = set_codes[CODE_W*b +: CODE_W];
        ev.any_active    = any;
        ev.last          = 1'b0;
        expected_events.push_back(ev);
      end
    end
    ev.kind          = KIND_STATUS;
    ev.binding_index = '0;
    ev.keycode       = '0;
    ev.any_active    = any;
    ev.last          = 1'b1;
    expected_events.push_back(ev);
    last_level = cur;
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------
  task automatic flag_error(string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic compare_event(out_item_t got);
    out_item_t want;
    if (expected_events.size() == 0) begin
      flag_error($sformatf("result transaction with nothing expected (kind %0d)", got.kind));
      return;
    end
    want = expected_events.pop_front();
    if (got.kind !== want.kind)
      flag_error($sformatf("result %0d kind %0d, want %0d", results_checked, got.kind,
                           want.kind));
    if (got.binding_index !== want.binding_index)
      flag_error($sformatf("result %0d binding %0d, want %0d", results_checked,
                           got.binding_index, want.binding_index));
    if (got.keycode !== want.keycode)
      flag_error($sformatf("result %0d keycode %h, want %h", results_checked, got.keycode,
                           want.keycode));
    if (got.any_active !== want.any_active)
      flag_error($sformatf("result %0d any_active %b, want %b", results_checked,
                           got.any_active, want.any_active));
    if (got.last !== want.last)
      flag_error($sformatf("result %0d last %b, want %b", results_checked, got.last,
                           want.last));
    results_checked++;
  endtask

  // ---------------------------------------------------------------------
  // clock and timeout
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous timeout, far beyond what the test needs
  initial begin
    #2_000_000;
    $display("analog_key_stroke_trigger_test: errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // monitor: results checked first, then any scan taken this edge predicted
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) compare_event(out_ch.data);
      if (in_ch.valid && in_ch.ready) begin
        scans_taken++;
        predict_key_scan(in_ch.data);
      end
    end
  end

  // ---------------------------------------------------------------------
  // driver: bursts of random length with random gaps, fed from pending_scans
  // ---------------------------------------------------------------------
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (scans_taken == scans_driven) begin
      // bus is free: either the last transaction went or nothing was offered
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_scans.size() > 0) begin
        in_ch.data  <= pending_scans.pop_front();
        in_ch.valid <= 1'b1;
        scans_driven++;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: ready follows an 8-bit pattern, reloaded each time round
  // ---------------------------------------------------------------------
  logic [7:0]  rx_pattern = 8'hFF;
  int unsigned rx_bit     = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= rx_pattern[rx_bit];
      if (rx_bit == 7) begin
        rx_bit = 0;
        case ($urandom_range(0, 4))
          0, 1:    rx_pattern = 8'hFF;             // no stall at all
          2:       rx_pattern = 8'h81;             // long stall
          3:       rx_pattern = 8'b1010_0110;
          default: rx_pattern = 8'($urandom()) | 8'h01;
        endcase
      end else begin
        rx_bit++;
      end
    end
  end

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_FLOOR:     set_floor         = value[LEVEL_W-1:0];
      CFG_PRESS_BEG: set_press_begin   = value[LEVEL_W-1:0];
      CFG_PRESS_FUL: set_press_full    = value[LEVEL_W-1:0];
      CFG_REL_BEG:   set_release_begin = value[LEVEL_W-1:0];
      CFG_REL_FUL:   set_release_full  = value[LEVEL_W-1:0];
      CFG_CONTROLS:  set_controls      = value[CTL_W-1:0];
      CFG_CODES:     set_codes         = value;
      default:       ;                 // unknown index, ignored
    endcase
  endtask

  task automatic apply_settings(logic [LEVEL_W-1:0] floor_lvl, logic [LEVEL_W-1:0] pb,
                                logic [LEVEL_W-1:0] pf, logic [LEVEL_W-1:0] rb,
                                logic [LEVEL_W-1:0] rf, logic [CTL_W-1:0] ctl,
                                logic [CFG_W-1:0] codes);
    write_reg(CFG_FLOOR, CFG_W'(floor_lvl));
    write_reg(CFG_PRESS_BEG, CFG_W'(pb));
    write_reg(CFG_PRESS_FUL, CFG_W'(pf));
    write_reg(CFG_REL_BEG, CFG_W'(rb));
    write_reg(CFG_REL_FUL, CFG_W'(rf));
    write_reg(CFG_CONTROLS, CFG_W'(ctl));
    write_reg(CFG_CODES, codes);
    settings_used++;
  endtask

  // press thresholds in order, release thresholds anywhere
  task automatic randomise_settings(logic [CTL_W-1:0] ctl);
    int unsigned pb;
    pb = $urandom_range(1, 30000);
    apply_settings(LEVEL_W'($urandom_range(0, 3000)), LEVEL_W'(pb),
                   LEVEL_W'(pb + $urandom_range(0, 30000)),
                   LEVEL_W'($urandom_range(0, 60000)), LEVEL_W'($urandom_range(0, 30000)),
                   ctl, {$urandom(), $urandom()});
  endtask

  function automatic void queue_scan_at(logic [LEVEL_W-1:0] lvl, logic [TICK_W-1:0] tick);
    in_item_t scan;
    scan.analog_level = lvl;
    scan.tick_now     = tick;
    tick_base         = tick;
    pending_scans.push_back(scan);
  endfunction

  // ticks mostly creep forward so taps both survive and expire,
  // with the odd jump, some of them to just short of the wrap
  function automatic void queue_scan(logic [LEVEL_W-1:0] lvl);
    logic [TICK_W-1:0] tick;
    case ($urandom_range(0, 24))
      0:       tick = $urandom();
      1:       tick = ENDLESS - TICK_W'($urandom_range(0, 8));
      default: tick = tick_base + TICK_W'($urandom_range(0, 4));
    endcase
    queue_scan_at(lvl, tick);
  endfunction

  // mostly whole strokes (ramp up to a peak and back down), some noise
  task automatic queue_random_scans(int unsigned count);
    int unsigned peak;
    int unsigned steps;
    int unsigned n;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 7) begin
        peak  = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
        steps = $urandom_range(1, 4);
        for (int s = 1; s <= steps; s++) begin
          queue_scan(LEVEL_W'((peak * s) / steps));
          n++;
        end
        steps = $urandom_range(1, 4);
        for (int s = steps - 1; s >= 0; s--) begin
          queue_scan(LEVEL_W'((peak * s) / steps));
          n++;
        end
      end else begin
        queue_scan(LEVEL_W'($urandom()));
        n++;
      end
    end
  endtask

  // wait for the scans to go and every expected transaction to arrive
  task automatic settle();
    do @(negedge clk);
    while (pending_scans.size() != 0 || scans_taken != scans_driven ||
           expected_events.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.data   = '0;
    out_ch.ready = 1'b0;
    clear_key_state();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // binding 0 taps on press begin, binding 1 holds on press fully,
    // binding 2 taps on release begin, binding 3 holds on press begin and release fully
    apply_settings(16'd100, 16'd200, 16'd800, 16'd600, 16'd150, 32'hC310_0C01,
                   64'h0000_FFFF_00E1_0004);
    queue_scan_at(16'd0, 32'd10);              // equal to the reset level
    queue_scan_at(16'd500, 32'd11);            // press begin
    queue_scan_at(16'd1000, 32'd12);           // press fully clears the others
    queue_scan_at(16'd1000, 32'd13);           // no movement
    queue_scan_at(16'd500, 32'd14);            // release begin
    queue_scan_at(16'd200, 32'd20);            // release fully, binding 2 gone too
    queue_scan_at(16'hFFFF, 32'd21);           // both press phases in one scan
    queue_scan_at(16'd0, 32'd22);              // both release phases in one scan
    queue_scan_at(16'd50, 32'd23);             // rise that stays under the floor
    queue_scan_at(16'd500, 32'hFFFF_FFFD);     // tap end time wraps, gone at once
    queue_scan_at(16'd0, 32'd100);
    queue_scan_at(16'd500, 32'd200);           // tap ends at 205
    queue_scan_at(16'd500, 32'd205);           // still alive on its end tick
    queue_scan_at(16'd500, 32'd206);           // tap expires
    queue_scan_at(16'd500, 32'hFFFF_FFFF);     // hold survives the top tick
    queue_scan_at(16'd0, 32'd0);
    settle();

    randomise_settings($urandom());
    queue_random_scans(20);
    settle();

    randomise_settings($urandom());
    queue_random_scans(15);
    settle();

    // everything under the floor and unreachable levels: nothing should fire
    apply_settings(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_random_scans(8);
    settle();

    // no floor, press begin only at full travel, release begin only at zero
    apply_settings(16'h0000, 16'hFFFF, 16'h0001, 16'h0000, 16'hFFFE, 32'h5A5A_A5A5,
                   {$urandom(), $urandom()});
    queue_random_scans(10);
    settle();

    // every phase enabled and held on every binding
    randomise_settings(32'hFFFF_FFFF);
    queue_random_scans(10);
    settle();

    randomise_settings($urandom());
    queue_random_scans(15);
    settle();

    repeat (10) @(posedge clk);
    if (expected_events.size() != 0)
      flag_error($sformatf("%0d result transactions never arrived", expected_events.size()));

    $display("covered %0d key scans under %0d threshold settings, %0d result transactions checked",
             scans_taken, settings_used, results_checked);
    if (mismatches == 0) begin
      $display("analog_key_stroke_trigger_test: clean");
    end else begin
      $display("analog_key_stroke_trigger_test: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
src/aks_pkg.sv
src/aks_in_if.sv
src/aks_out_if.sv
src/aks_step.sv
src/analog_key_stroke_trigger.sv
src/aks_chk.sv
tb/sv/analog_key_stroke_trigger_test.sv
